[rtl/core/ffsu_pkg.sv]
// Shared constants and helpers for the float floor and fraction split unit.
// No dependencies; imported by float_floor_fraction_split_unit.
`default_nettype none

package ffsu_pkg;

    localparam int unsigned FLOAT_W = 32;
    localparam int unsigned MANT_W  = 24;

    // Biased exponent of the top in-range binade, and the significand limit there.
    // 2.1e9 equals 16406250 * 2^7, so the limit is exact at exponent 157.
    localparam logic [7:0]        LIMIT_EXP  = 8'd157;
    localparam logic [MANT_W-1:0] LIMIT_MANT = 24'd16406250;
    localparam logic [7:0]        EXP_SPECIAL = 8'hFF;
    localparam logic [7:0]        EXP_HALF    = 8'd126;
    localparam logic [7:0]        EXP_ONE     = 8'd127;
    localparam logic [FLOAT_W-1:0] FLOAT_ONE  = 32'h3F80_0000;

    // Turns an exact value v * 2^-24 (v at most 2^24) into a float32 pattern.
    function automatic logic [FLOAT_W-1:0] fixed_to_float(input logic [MANT_W:0] v);
        logic [4:0]      pos;
        logic [MANT_W:0] sh;
        logic [7:0]      expo;
        pos = 5'd0;
        for (int i = 0; i <= MANT_W; i++) begin
            if (v[i]) begin
                pos = 5'(i);
            end
        end
        sh   = v << (5'd24 - pos);
        expo = 8'd103 + {3'b000, pos};
        if (v == '0) begin
            fixed_to_float = '0;
        end else begin
            fixed_to_float = {1'b0, expo, sh[23:1]};
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/float_floor_fraction_split_unit.sv]
// Float32 floor and fraction split: integer part plus float32 remainder.
// Depends on ffsu_pkg for constants and the fixed-to-float normaliser.
//
// Usage: one float32 request enters on the slave channel (s_axis_tdata holds
// the raw bit pattern). Each request yields exactly one result on the master
// channel: m_axis_tdata carries the integer part (low 32 bits, two's
// complement) and the remainder as a float32 pattern (high 32 bits);
// m_axis_tuser carries the out-of-range flag, set for NaN, infinities and
// magnitudes of 2.1e9 or more, in which case tdata is zero.
// The request is captured in the input register at its accepting edge and moves
// into the result register once that register is empty or being taken, with the
// whole split computed between the two registers. Throughput is one request per
// cycle while the receiver does not stall; the input register and result
// register advance together whenever the result register is empty or taken.
// When the receiver stalls, the result is held and the input register still
// takes one more request before s_axis_tready falls.
// The synchronous active-low reset empties both stages; no data is lost
// other than requests in flight at reset.
`default_nettype none

module float_floor_fraction_split_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // s_axis_tdata: [31:0] x_bits
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // m_axis_tdata: [31:0] int_part, [63:32] remainder_bits
    output logic [63:0]      m_axis_tdata,
    // m_axis_tuser: [0] out_of_range
    output logic             m_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready
);
    import ffsu_pkg::*;

    logic                r_v1;
    logic [FLOAT_W-1:0]  r_x;
    logic                r_v2;
    logic [63:0]         r_data;
    logic                r_oor;

    logic                adv2;
    logic                sgn;
    logic [7:0]          bexp;
    logic [MANT_W-1:0]   mant;
    logic                oor;
    logic                positive;
    logic [30:0]         trunc_mag;
    logic [31:0]         n_int;
    logic [FLOAT_W-1:0]  n_rem;
    logic [7:0]          exact_sh;
    logic [MANT_W-1:0]   frac24;
    logic [6:0]          rnd_sh;
    logic [4:0]          rnd_shc;
    logic [51:0]         wide;
    logic [26:0]         d3;
    logic [27:0]         tdiff;
    logic                rnd_up;
    logic [MANT_W:0]     rnd_mant;

    // Both stages move when the result register is free or being taken.
    assign adv2          = !r_v2 || m_axis_tready;
    assign s_axis_tready = !r_v1 || adv2;

    // Field decode and range check.
    always_comb begin
        sgn  = r_x[31];
        bexp = r_x[30:23];
        mant = {bexp != 8'd0, r_x[22:0]};
        oor  = (bexp == EXP_SPECIAL) || (bexp > LIMIT_EXP) ||
               ((bexp == LIMIT_EXP) && (mant >= LIMIT_MANT));
        positive = !sgn && (r_x[30:0] != 31'd0);
    end

    // Integer part: truncated magnitude, complemented for non-positive inputs.
    always_comb begin
        if (bexp < EXP_ONE || oor) begin
            trunc_mag = '0;
        end else begin
            trunc_mag = {mant, 7'b0} >> 5'(LIMIT_EXP - bexp);
        end
        n_int = positive ? {1'b0, trunc_mag} : ~{1'b0, trunc_mag};
    end

    // Fraction of |x| scaled by 2^24, exact for magnitudes of one half or more.
    always_comb begin
        exact_sh = bexp - EXP_HALF;
        if (bexp < EXP_HALF || exact_sh > 8'd23) begin
            frac24 = '0;
        end else begin
            frac24 = mant << exact_sh[4:0];
        end
    end

    // Small negative inputs: 1 - |x| rounded to nearest even with guard and sticky.
    always_comb begin
        rnd_sh   = 7'(EXP_HALF - bexp);
        rnd_shc  = (rnd_sh > 7'd27) ? 5'd27 : rnd_sh[4:0];
        wide     = {mant, 2'b00, 26'b0} >> rnd_shc;
        d3       = {wide[51:26], |wide[25:0]};
        tdiff    = 28'h800_0000 - {1'b0, d3};
        rnd_up   = tdiff[2] && (tdiff[1] || tdiff[0] || tdiff[3]);
        rnd_mant = tdiff[27:3] + {24'd0, rnd_up};
    end

    // Remainder selection.
    always_comb begin
        if (oor) begin
            n_rem = '0;
        end else if (bexp < EXP_HALF) begin
            if (positive) begin
                n_rem = r_x;
            end else if (rnd_mant[MANT_W]) begin
                n_rem = FLOAT_ONE;
            end else begin
                n_rem = {1'b0, EXP_HALF, rnd_mant[22:0]};
            end
        end else if (positive) begin
            n_rem = fixed_to_float({1'b0, frac24});
        end else if (frac24 == '0) begin
            n_rem = FLOAT_ONE;
        end else begin
            n_rem = fixed_to_float(25'h100_0000 - {1'b0, frac24});
        end
    end

    // Input and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_v1 <= s_axis_tvalid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_x <= s_axis_tdata;
        end
        if (adv2 && r_v1) begin
            r_data <= oor ? 64'd0 : {n_rem, n_int};
            r_oor  <= oor;
        end
    end

    assign m_axis_tdata  = r_data;
    assign m_axis_tuser  = r_oor;
    assign m_axis_tvalid = r_v2;

    // An out-of-range result carries zero data.
    a_oor_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 64'd0)
        else $error("out-of-range result with non-zero data");

    // A valid in-range remainder never exceeds 1.0.
    a_rem_le_one : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:32] <= FLOAT_ONE)
        else $error("remainder above one");

    // A negative integer part always leaves a non-zero remainder.
    a_neg_rem : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser && m_axis_tdata[31] |->
        m_axis_tdata[63:32] != 32'd0)
        else $error("negative integer part with zero remainder");

    // A held input request is not dropped while the result stage stalls.
    a_hold_stage1 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !adv2 |=> r_v1)
        else $error("input stage lost a request");

endmodule

`default_nettype wire
